FILE: design/fbsia_pkg.sv
`timescale 1ns / 1ps
package fbsia_pkg;

   localparam int NUM_BLOCKS  = 1024;
   localparam int BLK_W       = 10;
   localparam int CNT_W       = 11;
   localparam int BYTES_W     = 14;
   localparam int BLOCK_BYTES = 10;

   localparam logic [2:0] CMD_FORMAT = 3'd0;
   localparam logic [2:0] CMD_ALLOC  = 3'd1;
   localparam logic [2:0] CMD_CREATE = 3'd2;
   localparam logic [2:0] CMD_MARK   = 3'd3;
   localparam logic [2:0] CMD_DELETE = 3'd4;
   localparam logic [2:0] CMD_LIST   = 3'd5;
   localparam logic [2:0] CMD_STATE  = 3'd6;
   localparam logic [2:0] CMD_COUNT  = 3'd7;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_NO_BLOCK  = 3'd1;
   localparam logic [2:0] ST_TOO_LARGE = 3'd2;
   localparam logic [2:0] ST_NO_INODE  = 3'd3;
   localparam logic [2:0] ST_BAD_BLOCK = 3'd4;
   localparam logic [2:0] ST_BAD_INODE = 3'd5;

   localparam logic [1:0] KIND_FREE = 2'd0;
   localparam logic [1:0] KIND_BAD  = 2'd1;
   localparam logic [1:0] KIND_FILE = 2'd2;

   // where the pending response takes its fields from
   localparam logic [2:0] SRC_NONE   = 3'd0;
   localparam logic [2:0] SRC_FMT    = 3'd1;
   localparam logic [2:0] SRC_ALLOC  = 3'd2;
   localparam logic [2:0] SRC_CREATE = 3'd3;
   localparam logic [2:0] SRC_DEL    = 3'd4;
   localparam logic [2:0] SRC_KIND   = 3'd5;
   localparam logic [2:0] SRC_FILL   = 3'd6;

   typedef struct packed {
      logic       latch;
      logic       fmt_start;
      logic       sweep;
      logic       pop_rd;
      logic       pop_wr;
      logic       slot_set;
      logic       scan_start;
      logic       scan_next;
      logic       found;
      logic       k_step;
      logic       create_done;
      logic       mark;
      logic       row_load;
      logic       del_slot;
      logic       del_done;
      logic       list_emit;
      logic       res_load;
      logic [2:0] res_status;
      logic [2:0] res_src;
      logic       emit;
   } dp_ctl_type;

   typedef struct packed {
      logic [2:0] cmd;
      logic       fill_zero;
      logic       too_big;
      logic       bi_bad;
      logic       ii_bad;
      logic       sweep_done;
      logic       bytes_zero;
      logic       scan_end;
      logic       k_at_need;
      logic       k_at_end;
      logic       slot_valid;
      logic       list_none;
      logic       list_last;
      logic       out_free;
   } dp_sts_type;

endpackage

FILE: design/fbsia_datapath.sv
`timescale 1ns / 1ps
module fbsia_datapath #(
   parameter int NUM_INODES   = 1024,
   parameter int DIRECT_SLOTS = 5
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [2:0]                  req_command,
   input  logic [fbsia_pkg::BLK_W-1:0] req_block_index,
   input  logic [fbsia_pkg::BLK_W-1:0] req_inode_index,
   input  logic [fbsia_pkg::BYTES_W-1:0] req_file_bytes,
   input  logic                        csr_we,
   input  logic [fbsia_pkg::CNT_W-1:0] csr_value,
   input  fbsia_pkg::dp_ctl_type       ctl,
   output fbsia_pkg::dp_sts_type       sts,
   input  logic                        rsp_taken,
   output logic                        rsp_valid,
   output logic [2:0]                  rsp_status,
   output logic [fbsia_pkg::BLK_W-1:0] rsp_block,
   output logic [fbsia_pkg::BLK_W-1:0] rsp_inode,
   output logic [1:0]                  rsp_kind,
   output logic [fbsia_pkg::CNT_W-1:0] rsp_count,
   output logic                        rsp_last
);
   import fbsia_pkg::*;

   localparam int IW        = (NUM_INODES > 1) ? $clog2(NUM_INODES) : 1;
   localparam int SLOT_W    = BLK_W + 1;
   localparam int ROW_W     = DIRECT_SLOTS * SLOT_W;
   localparam int KW        = $clog2(DIRECT_SLOTS + 1);
   localparam int SWEEP_LEN = (NUM_INODES > NUM_BLOCKS) ? NUM_INODES : NUM_BLOCKS;
   localparam int SW        = $clog2(SWEEP_LEN);

   // memories
   logic [1:0]         map_mem   [NUM_BLOCKS];
   logic [BLK_W-1:0]   stack_mem [NUM_BLOCKS];
   logic [BYTES_W-1:0] bytes_mem [NUM_INODES];
   logic [ROW_W-1:0]   slots_mem [NUM_INODES];

   logic [1:0]         map_rd_ff;
   logic [BLK_W-1:0]   stack_rd_ff;
   logic [BYTES_W-1:0] bytes_rd_ff;
   logic [ROW_W-1:0]   slots_rd_ff;

   logic [CNT_W-1:0] disk_blocks_ff, disk_blocks_in;
   logic [CNT_W-1:0] disk_size_ff, disk_size_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic [SW-1:0]    cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;

   logic [2:0]         cmd_ff;
   logic [BLK_W-1:0]   bi_ff, ii_ff;
   logic [BYTES_W-1:0] fb_ff;
   logic [IW-1:0]      ino_ff, ino_in;
   logic [KW-1:0]      k_ff, k_in, got_ff, got_in, n_ff, n_in, j_ff, j_in;
   logic [ROW_W-1:0]   row_ff, row_in;

   logic [2:0]       res_status_ff, res_status_in;
   logic [BLK_W-1:0] res_block_ff, res_block_in, res_inode_ff, res_inode_in;
   logic [1:0]       res_kind_ff, res_kind_in;
   logic [CNT_W-1:0] res_count_ff, res_count_in;

   logic [2:0]       rsp_status_ff, rsp_status_in;
   logic [BLK_W-1:0] rsp_block_ff, rsp_block_in, rsp_inode_ff, rsp_inode_in;
   logic [1:0]       rsp_kind_ff, rsp_kind_in;
   logic [CNT_W-1:0] rsp_count_ff, rsp_count_in;
   logic             rsp_last_ff, rsp_last_in;

   logic [CNT_W-1:0] fmt_n;
   logic [KW-1:0]    need, pop_n;
   logic [SLOT_W-1:0] cur_slot;
   logic             push_ok;
   logic [IW-1:0]    ii_addr, bytes_ra;

   logic             map_we;
   logic [BLK_W-1:0] map_wa;
   logic [1:0]       map_wd;
   logic             stack_we;
   logic [BLK_W-1:0] stack_wa, stack_wd;
   logic             bytes_we, slots_we;
   logic [IW-1:0]    inode_wa;
   logic [BYTES_W-1:0] bytes_wd;
   logic [ROW_W-1:0] slots_wd;

   assign ii_addr  = IW'(ii_ff);
   assign cur_slot = row_ff[k_ff*SLOT_W +: SLOT_W];
   assign fmt_n    = (disk_blocks_ff > CNT_W'(NUM_BLOCKS)) ? CNT_W'(NUM_BLOCKS)
                                                           : disk_blocks_ff;
   assign push_ok  = cur_slot[BLK_W] && (CNT_W'(cur_slot[BLK_W-1:0]) < disk_size_ff)
                     && (fill_ff != CNT_W'(NUM_BLOCKS));

   // blocks wanted by create, capped at the slot count
   always_comb begin
      need = '0;
      for (int i = 0; i < DIRECT_SLOTS; i++) begin
         if (32'(fb_ff) > i * BLOCK_BYTES) need = need + KW'(1);
      end
   end

   always_comb begin
      pop_n = '0;
      for (int i = 0; i < DIRECT_SLOTS; i++) begin
         if (slots_rd_ff[i*SLOT_W + BLK_W]) pop_n = pop_n + KW'(1);
      end
   end

   always_comb begin
      sts            = '0;
      sts.cmd        = cmd_ff;
      sts.fill_zero  = (fill_ff == '0);
      sts.too_big    = 15'(fb_ff) > (15'(disk_size_ff) * 15'(BLOCK_BYTES));
      sts.bi_bad     = CNT_W'(bi_ff) >= disk_size_ff;
      sts.ii_bad     = 32'(ii_ff) >= NUM_INODES;
      sts.sweep_done = (cnt_ff == SW'(SWEEP_LEN - 1));
      sts.bytes_zero = (bytes_rd_ff == '0);
      sts.scan_end   = (ino_ff == IW'(NUM_INODES - 1));
      sts.k_at_need  = (k_ff == need);
      sts.k_at_end   = (k_ff == KW'(DIRECT_SLOTS));
      sts.slot_valid = cur_slot[BLK_W];
      sts.list_none  = (pop_n == '0);
      sts.list_last  = ((j_ff + KW'(1)) == n_ff);
      sts.out_free   = !rsp_valid_ff || rsp_taken;
   end

   // write ports
   always_comb begin
      map_we   = 1'b0;
      map_wa   = cnt_ff[BLK_W-1:0];
      map_wd   = KIND_FREE;
      stack_we = 1'b0;
      stack_wa = cnt_ff[BLK_W-1:0];
      stack_wd = cnt_ff[BLK_W-1:0];
      bytes_we = 1'b0;
      slots_we = 1'b0;
      inode_wa = IW'(cnt_ff);
      bytes_wd = '0;
      slots_wd = '0;
      bytes_ra = ii_addr;
      if (ctl.sweep) begin
         map_we   = 32'(cnt_ff) < NUM_BLOCKS;
         stack_we = 32'(cnt_ff) < 32'(disk_size_ff);
         bytes_we = 32'(cnt_ff) < NUM_INODES;
         slots_we = 32'(cnt_ff) < NUM_INODES;
      end
      if (ctl.pop_wr) begin
         map_we = 1'b1;
         map_wa = stack_rd_ff;
         map_wd = KIND_FILE;
      end
      if (ctl.mark) begin
         map_we = 1'b1;
         map_wa = bi_ff;
         map_wd = KIND_BAD;
      end
      if (ctl.del_slot && push_ok) begin
         map_we   = 1'b1;
         map_wa   = cur_slot[BLK_W-1:0];
         stack_we = 1'b1;
         stack_wa = fill_ff[BLK_W-1:0];
         stack_wd = cur_slot[BLK_W-1:0];
      end
      if (ctl.found) begin
         bytes_we = 1'b1;
         inode_wa = ino_ff;
         bytes_wd = fb_ff;
      end
      if (ctl.create_done) begin
         slots_we = 1'b1;
         inode_wa = ino_ff;
         slots_wd = row_ff;
      end
      if (ctl.del_done) begin
         bytes_we = 1'b1;
         slots_we = 1'b1;
         inode_wa = ii_addr;
      end
      if (ctl.scan_start) bytes_ra = '0;
      else if (ctl.scan_next) bytes_ra = ino_ff + IW'(1);
   end

   always_ff @(posedge clock) begin
      if (map_we) map_mem[map_wa] <= map_wd;
      map_rd_ff <= map_mem[bi_ff];
   end

   always_ff @(posedge clock) begin
      if (stack_we) stack_mem[stack_wa] <= stack_wd;
      stack_rd_ff <= stack_mem[BLK_W'(fill_ff - CNT_W'(1))];
   end

   always_ff @(posedge clock) begin
      if (bytes_we) bytes_mem[inode_wa] <= bytes_wd;
      bytes_rd_ff <= bytes_mem[bytes_ra];
   end

   always_ff @(posedge clock) begin
      if (slots_we) slots_mem[inode_wa] <= slots_wd;
      slots_rd_ff <= slots_mem[ii_addr];
   end

   // control registers
   always_comb begin
      disk_blocks_in = csr_we ? csr_value : disk_blocks_ff;
      disk_size_in   = ctl.fmt_start ? fmt_n : disk_size_ff;
      cnt_in         = ctl.fmt_start ? '0 : (ctl.sweep ? cnt_ff + SW'(1) : cnt_ff);
      fill_in        = fill_ff;
      if (ctl.fmt_start) fill_in = fmt_n;
      else if (ctl.pop_rd) fill_in = fill_ff - CNT_W'(1);
      else if (ctl.del_slot && push_ok) fill_in = fill_ff + CNT_W'(1);
      rsp_valid_in = rsp_valid_ff && !rsp_taken;
      if (ctl.emit || ctl.list_emit) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         disk_blocks_ff <= CNT_W'(1024);
         disk_size_ff   <= '0;
         fill_ff        <= '0;
         cnt_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         disk_blocks_ff <= disk_blocks_in;
         disk_size_ff   <= disk_size_in;
         fill_ff        <= fill_in;
         cnt_ff         <= cnt_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // payload and walk registers
   always_comb begin
      ino_in = ino_ff;
      if (ctl.scan_start) ino_in = '0;
      else if (ctl.scan_next) ino_in = ino_ff + IW'(1);
      k_in   = k_ff;
      got_in = got_ff;
      n_in   = n_ff;
      j_in   = j_ff;
      row_in = row_ff;
      if (ctl.found) begin
         k_in   = '0;
         got_in = '0;
         row_in = '0;
      end
      if (ctl.row_load) begin
         k_in   = '0;
         j_in   = '0;
         n_in   = pop_n;
         row_in = slots_rd_ff;
      end
      if (ctl.slot_set) begin
         row_in[k_ff*SLOT_W +: SLOT_W] = {1'b1, stack_rd_ff};
         got_in = got_ff + KW'(1);
      end
      if (ctl.k_step || ctl.slot_set || ctl.del_slot || ctl.list_emit) k_in = k_ff + KW'(1);
      if (ctl.list_emit) j_in = j_ff + KW'(1);

      res_status_in = res_status_ff;
      res_block_in  = res_block_ff;
      res_inode_in  = res_inode_ff;
      res_kind_in   = res_kind_ff;
      res_count_in  = res_count_ff;
      if (ctl.res_load) begin
         res_status_in = ctl.res_status;
         res_block_in  = (ctl.res_src == SRC_ALLOC) ? stack_rd_ff : '0;
         res_inode_in  = (ctl.res_src == SRC_CREATE) ? BLK_W'(ino_ff) : '0;
         res_kind_in   = (ctl.res_src == SRC_KIND) ? map_rd_ff : KIND_FREE;
         unique case (ctl.res_src)
            SRC_FMT:    res_count_in = disk_size_ff;
            SRC_CREATE: res_count_in = CNT_W'(got_ff);
            SRC_DEL:    res_count_in = CNT_W'(n_ff);
            SRC_FILL:   res_count_in = fill_ff;
            default:    res_count_in = '0;
         endcase
      end

      rsp_status_in = rsp_status_ff;
      rsp_block_in  = rsp_block_ff;
      rsp_inode_in  = rsp_inode_ff;
      rsp_kind_in   = rsp_kind_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_last_in   = rsp_last_ff;
      if (ctl.emit) begin
         rsp_status_in = res_status_ff;
         rsp_block_in  = res_block_ff;
         rsp_inode_in  = res_inode_ff;
         rsp_kind_in   = res_kind_ff;
         rsp_count_in  = res_count_ff;
         rsp_last_in   = 1'b1;
      end else if (ctl.list_emit) begin
         rsp_status_in = ST_OK;
         rsp_block_in  = cur_slot[BLK_W-1:0];
         rsp_inode_in  = '0;
         rsp_kind_in   = KIND_FREE;
         rsp_count_in  = CNT_W'(n_ff);
         rsp_last_in   = sts.list_last;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.latch) begin
         cmd_ff <= req_command;
         bi_ff  <= req_block_index;
         ii_ff  <= req_inode_index;
         fb_ff  <= req_file_bytes;
      end
      ino_ff        <= ino_in;
      k_ff          <= k_in;
      got_ff        <= got_in;
      n_ff          <= n_in;
      j_ff          <= j_in;
      row_ff        <= row_in;
      res_status_ff <= res_status_in;
      res_block_ff  <= res_block_in;
      res_inode_ff  <= res_inode_in;
      res_kind_ff   <= res_kind_in;
      res_count_ff  <= res_count_in;
      rsp_status_ff <= rsp_status_in;
      rsp_block_ff  <= rsp_block_in;
      rsp_inode_ff  <= rsp_inode_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_block  = rsp_block_ff;
   assign rsp_inode  = rsp_inode_ff;
   assign rsp_kind   = rsp_kind_ff;
   assign rsp_count  = rsp_count_ff;
   assign rsp_last   = rsp_last_ff;

endmodule

FILE: design/fbsia_ctrl.sv
`timescale 1ns / 1ps
module fbsia_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  fbsia_pkg::dp_sts_type sts,
   output fbsia_pkg::dp_ctl_type ctl
);
   import fbsia_pkg::*;

   localparam logic [3:0] S_CLEAR    = 4'd0;
   localparam logic [3:0] S_IDLE     = 4'd1;
   localparam logic [3:0] S_DISPATCH = 4'd2;
   localparam logic [3:0] S_FMT      = 4'd3;
   localparam logic [3:0] S_POPW     = 4'd4;
   localparam logic [3:0] S_SCAN     = 4'd5;
   localparam logic [3:0] S_CPOP     = 4'd6;
   localparam logic [3:0] S_CPOPW    = 4'd7;
   localparam logic [3:0] S_DCHK     = 4'd8;
   localparam logic [3:0] S_DSLOT    = 4'd9;
   localparam logic [3:0] S_LCHK     = 4'd10;
   localparam logic [3:0] S_LSCAN    = 4'd11;
   localparam logic [3:0] S_KIND     = 4'd12;
   localparam logic [3:0] S_EMIT     = 4'd13;

   logic [3:0] state_ff, state_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      ctl      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: begin
            ctl.sweep = 1'b1;
            if (sts.sweep_done) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               ctl.latch = 1'b1;
               state_in  = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            ctl.res_status = ST_OK;
            ctl.res_src    = SRC_NONE;
            state_in       = S_EMIT;
            unique case (sts.cmd)
               CMD_FORMAT: begin
                  ctl.fmt_start = 1'b1;
                  state_in      = S_FMT;
               end
               CMD_ALLOC: begin
                  if (sts.fill_zero) begin
                     ctl.res_load   = 1'b1;
                     ctl.res_status = ST_NO_BLOCK;
                  end else begin
                     ctl.pop_rd = 1'b1;
                     state_in   = S_POPW;
                  end
               end
               CMD_CREATE: begin
                  if (sts.too_big) begin
                     ctl.res_load   = 1'b1;
                     ctl.res_status = ST_TOO_LARGE;
                  end else begin
                     ctl.scan_start = 1'b1;
                     state_in       = S_SCAN;
                  end
               end
               CMD_MARK: begin
                  ctl.res_load = 1'b1;
                  if (sts.bi_bad) ctl.res_status = ST_BAD_BLOCK;
                  else ctl.mark = 1'b1;
               end
               CMD_DELETE, CMD_LIST: begin
                  if (sts.ii_bad) begin
                     ctl.res_load   = 1'b1;
                     ctl.res_status = ST_BAD_INODE;
                  end else begin
                     state_in = (sts.cmd == CMD_DELETE) ? S_DCHK : S_LCHK;
                  end
               end
               CMD_STATE: begin
                  if (sts.bi_bad) begin
                     ctl.res_load   = 1'b1;
                     ctl.res_status = ST_BAD_BLOCK;
                  end else begin
                     state_in = S_KIND;
                  end
               end
               default: begin
                  ctl.res_load = 1'b1;
                  ctl.res_src  = SRC_FILL;
               end
            endcase
         end
         S_FMT: begin
            ctl.sweep = 1'b1;
            if (sts.sweep_done) begin
               ctl.res_load = 1'b1;
               ctl.res_src  = SRC_FMT;
               state_in     = S_EMIT;
            end
         end
         S_POPW: begin
            ctl.pop_wr   = 1'b1;
            ctl.res_load = 1'b1;
            ctl.res_src  = SRC_ALLOC;
            state_in     = S_EMIT;
         end
         S_SCAN: begin
            priority if (sts.bytes_zero) begin
               ctl.found = 1'b1;
               state_in  = S_CPOP;
            end else if (sts.scan_end) begin
               ctl.res_load   = 1'b1;
               ctl.res_status = ST_NO_INODE;
               state_in       = S_EMIT;
            end else begin
               ctl.scan_next = 1'b1;
            end
         end
         S_CPOP: begin
            priority if (sts.k_at_need) begin
               ctl.create_done = 1'b1;
               ctl.res_load    = 1'b1;
               ctl.res_src     = SRC_CREATE;
               state_in        = S_EMIT;
            end else if (sts.fill_zero) begin
               ctl.k_step = 1'b1;
            end else begin
               ctl.pop_rd = 1'b1;
               state_in   = S_CPOPW;
            end
         end
         S_CPOPW: begin
            ctl.pop_wr   = 1'b1;
            ctl.slot_set = 1'b1;
            state_in     = S_CPOP;
         end
         S_DCHK: begin
            if (sts.bytes_zero) begin
               ctl.res_load   = 1'b1;
               ctl.res_status = ST_BAD_INODE;
               state_in       = S_EMIT;
            end else begin
               ctl.row_load = 1'b1;
               state_in     = S_DSLOT;
            end
         end
         S_DSLOT: begin
            if (sts.k_at_end) begin
               ctl.del_done = 1'b1;
               ctl.res_load = 1'b1;
               ctl.res_src  = SRC_DEL;
               state_in     = S_EMIT;
            end else begin
               ctl.del_slot = 1'b1;
            end
         end
         S_LCHK: begin
            priority if (sts.bytes_zero) begin
               ctl.res_load   = 1'b1;
               ctl.res_status = ST_BAD_INODE;
               state_in       = S_EMIT;
            end else if (sts.list_none) begin
               ctl.res_load = 1'b1;
               state_in     = S_EMIT;
            end else begin
               ctl.row_load = 1'b1;
               state_in     = S_LSCAN;
            end
         end
         S_LSCAN: begin
            priority if (!sts.slot_valid) begin
               ctl.k_step = 1'b1;
            end else if (sts.out_free) begin
               ctl.list_emit = 1'b1;
               if (sts.list_last) state_in = S_IDLE;
            end
         end
         S_KIND: begin
            ctl.res_load = 1'b1;
            ctl.res_src  = SRC_KIND;
            state_in     = S_EMIT;
         end
         S_EMIT: begin
            if (sts.out_free) begin
               ctl.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_CLEAR;
      else state_ff <= state_in;
   end

endmodule

FILE: design/free_block_stack_inode_allocator.sv
`timescale 1ns / 1ps
// Free block stack allocator for a small inode store.
// Requests enter on req_* (tuser = command, tdata = block, inode, byte size);
// responses leave on rsp_* (tuser = status, tlast marks a command's final
// response). csr_* writes disk_blocks, which format applies.
// Work per request:
//   create: an inode search, one table read per cycle, then one pop per
//     block needed, up to DIRECT_SLOTS; a slot stays empty once the stack
//     is empty.
//   delete: every one of the DIRECT_SLOTS slots, one slot per cycle.
//   list: one response per used slot.
//   format: one map/inode/stack row per cycle.
// One request is worked on at a time; req_tready is high only when idle.
// After reset the block clears the block map and inode tables before
// req_tready rises; the store is then unformatted with an empty stack.
// csr writes are taken at any time.
// A response sits in the output register until rsp_tready; the next request
// is accepted meanwhile, and its own response waits behind it.
module free_block_stack_inode_allocator #(
   parameter int NUM_INODES   = 1024,
   parameter int DIRECT_SLOTS = 5
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,  // block_index[9:0], inode_no[19:10], file_bytes[33:20]
   input  logic [2:0]  req_tuser,  // command
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,  // result_block[9:0], result_inode[19:10],
                                   // block_kind[21:20], count[32:22]
   output logic [2:0]  rsp_tuser,  // status
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [10:0] csr_data
);
   import fbsia_pkg::*;

   dp_ctl_type       ctl;
   dp_sts_type       sts;
   logic [BLK_W-1:0] rsp_block, rsp_inode;
   logic [1:0]       rsp_kind;
   logic [CNT_W-1:0] rsp_count;

   // register writes are always accepted
   assign csr_ready = 1'b1;

   fbsia_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .sts       (sts),
      .ctl       (ctl)
   );

   fbsia_datapath #(
      .NUM_INODES   (NUM_INODES),
      .DIRECT_SLOTS (DIRECT_SLOTS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_command     (req_tuser),
      .req_block_index (req_tdata[9:0]),
      .req_inode_index (req_tdata[19:10]),
      .req_file_bytes  (req_tdata[33:20]),
      .csr_we          (csr_valid),
      .csr_value       (csr_data),
      .ctl             (ctl),
      .sts             (sts),
      .rsp_taken       (rsp_tready),
      .rsp_valid       (rsp_tvalid),
      .rsp_status      (rsp_tuser),
      .rsp_block       (rsp_block),
      .rsp_inode       (rsp_inode),
      .rsp_kind        (rsp_kind),
      .rsp_count       (rsp_count),
      .rsp_last        (rsp_tlast)
   );

   assign rsp_tdata = {7'd0, rsp_count, rsp_kind, rsp_inode, rsp_block};

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps
module testbench;
   import fbsia_pkg::*;

   localparam int INODES = 1024;
   localparam int SLOTS  = 5;
   localparam int WATCHDOG_LIMIT = 40000;

   // one request as offered on req_*, with an optional hand-typed answer
   typedef struct {
      logic [2:0]  cmd;
      logic [9:0]  blk;
      logic [9:0]  ino;
      logic [13:0] nbytes;
      bit          fixed;      // status and count typed in below
      logic [2:0]  fix_status;
      logic [10:0] fix_count;
   } alloc_req_type;

   typedef struct {
      logic [2:0]  status;
      logic [9:0]  blk;
      logic [9:0]  ino;
      logic [1:0]  kind;
      logic [10:0] count;
      logic        last;
   } alloc_rsp_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [39:0] req_tdata;   // block_index[9:0], inode_no[19:10], file_bytes[33:20]
   logic [2:0]  req_tuser;   // command
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;   // result_block[9:0], result_inode[19:10], kind[21:20], count[32:22]
   logic [2:0]  rsp_tuser;   // status
   logic        rsp_tlast;
   logic        csr_valid;
   logic        csr_ready;
   logic [10:0] csr_data;

   // typed answer travelling alongside the request on the bus
   logic        cur_fixed;
   logic [2:0]  cur_fix_status;
   logic [10:0] cur_fix_count;

   free_block_stack_inode_allocator dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Shadow copy of the store
   // ---------------------------------------------------------------------
   logic [1:0]  shadow_map [NUM_BLOCKS];
   logic [9:0]  shadow_stack [NUM_BLOCKS];
   int          shadow_fill;
   int          shadow_disk;        // size applied by the last format
   logic [10:0] shadow_blocks_reg;  // disk_blocks as written
   int          shadow_bytes [INODES];
   bit          shadow_linked [INODES];
   logic [10:0] shadow_slot [INODES][SLOTS]; // bit 10 = slot in use

   alloc_rsp_type pending_rsps [$];
   int  error_count;
   bit  no_idle;        // phase runs without gaps on either side
   bit  long_hold_req;  // receiver should hold off once for a long stretch

   function automatic void push_rsp(logic [2:0] st, logic [9:0] b, logic [9:0] i,
                                    logic [1:0] k, logic [10:0] c, logic l);
      alloc_rsp_type r;
      r.status = st; r.blk = b; r.ino = i; r.kind = k; r.count = c; r.last = l;
      pending_rsps.push_back(r);
   endfunction

   function automatic void shadow_clear();
      for (int i = 0; i < NUM_BLOCKS; i++) shadow_map[i] = KIND_FREE;
      for (int i = 0; i < INODES; i++) begin
         shadow_bytes[i] = 0;
         shadow_linked[i] = 1'b0;
         for (int s = 0; s < SLOTS; s++) shadow_slot[i][s] = '0;
      end
   endfunction

   function automatic bit shadow_pop(output logic [9:0] b);
      if (shadow_fill == 0) return 1'b0;
      shadow_fill--;
      b = shadow_stack[shadow_fill];
      shadow_map[b] = KIND_FILE;
      return 1'b1;
   endfunction

   // Applies one request to the shadow store and queues its responses.
   function automatic void predict_request(alloc_req_type q);
      logic [9:0] b;
      int n, got, ino, need, k;
      case (q.cmd)
         CMD_FORMAT: begin
            n = (shadow_blocks_reg > NUM_BLOCKS) ? NUM_BLOCKS : shadow_blocks_reg;
            shadow_disk = n;
            shadow_clear();
            for (int i = 0; i < n; i++) shadow_stack[i] = 10'(i);
            shadow_fill = n;
            push_rsp(ST_OK, 0, 0, KIND_FREE, 11'(n), 1'b1);
         end
         CMD_ALLOC: begin
            if (shadow_pop(b)) push_rsp(ST_OK, b, 0, KIND_FREE, 0, 1'b1);
            else push_rsp(ST_NO_BLOCK, 0, 0, KIND_FREE, 0, 1'b1);
         end
         CMD_CREATE: begin
            ino = -1;
            if (q.nbytes > shadow_disk * BLOCK_BYTES) begin
               push_rsp(ST_TOO_LARGE, 0, 0, KIND_FREE, 0, 1'b1);
            end else begin
               for (int i = 0; i < INODES; i++)
                  if (ino < 0 && shadow_bytes[i] == 0) ino = i;
               if (ino < 0) begin
                  push_rsp(ST_NO_INODE, 0, 0, KIND_FREE, 0, 1'b1);
               end else begin
                  shadow_bytes[ino] = q.nbytes;
                  shadow_linked[ino] = 1'b1;
                  need = (q.nbytes + BLOCK_BYTES - 1) / BLOCK_BYTES;
                  if (need > SLOTS) need = SLOTS;
                  got = 0;
                  // a failed pop leaves its slot empty
                  for (int s = 0; s < need; s++)
                     if (shadow_pop(b)) begin
                        shadow_slot[ino][s] = {1'b1, b};
                        got++;
                     end
                  push_rsp(ST_OK, 0, 10'(ino), KIND_FREE, 11'(got), 1'b1);
               end
            end
         end
         CMD_MARK: begin
            if (q.blk >= shadow_disk) push_rsp(ST_BAD_BLOCK, 0, 0, KIND_FREE, 0, 1'b1);
            else begin
               shadow_map[q.blk] = KIND_BAD;   // stays on the stack
               push_rsp(ST_OK, 0, 0, KIND_FREE, 0, 1'b1);
            end
         end
         CMD_DELETE: begin
            if (shadow_bytes[q.ino] == 0) push_rsp(ST_BAD_INODE, 0, 0, KIND_FREE, 0, 1'b1);
            else begin
               n = 0;
               for (int s = 0; s < SLOTS; s++)
                  if (shadow_slot[q.ino][s][10]) begin
                     b = shadow_slot[q.ino][s][9:0];
                     if (b < shadow_disk && shadow_fill < NUM_BLOCKS) begin
                        shadow_map[b] = KIND_FREE;
                        shadow_stack[shadow_fill] = b;
                        shadow_fill++;
                     end
                     shadow_slot[q.ino][s] = '0;
                     n++;
                  end
               shadow_bytes[q.ino] = 0;
               push_rsp(ST_OK, 0, 0, KIND_FREE, 11'(n), 1'b1);
            end
         end
         CMD_LIST: begin
            if (shadow_bytes[q.ino] == 0) push_rsp(ST_BAD_INODE, 0, 0, KIND_FREE, 0, 1'b1);
            else begin
               n = 0;
               for (int s = 0; s < SLOTS; s++) if (shadow_slot[q.ino][s][10]) n++;
               if (n == 0) push_rsp(ST_OK, 0, 0, KIND_FREE, 0, 1'b1);
               k = 0;
               for (int s = 0; s < SLOTS; s++)
                  if (shadow_slot[q.ino][s][10]) begin
                     k++;
                     push_rsp(ST_OK, shadow_slot[q.ino][s][9:0], 0, KIND_FREE, 11'(n),
                              k == n);
                  end
            end
         end
         CMD_STATE: begin
            if (q.blk >= shadow_disk) push_rsp(ST_BAD_BLOCK, 0, 0, KIND_FREE, 0, 1'b1);
            else push_rsp(ST_OK, 0, 0, shadow_map[q.blk], 0, 1'b1);
         end
         default: push_rsp(ST_OK, 0, 0, KIND_FREE, 11'(shadow_fill), 1'b1);
      endcase
      // rows with a hand-typed answer replace the predicted one
      if (q.fixed) begin
         pending_rsps[$] = '{q.fix_status, 10'd0, 10'd0, KIND_FREE, q.fix_count, 1'b1};
      end
   endfunction

   // ---------------------------------------------------------------------
   // Monitor: predicts on every accepted request, checks every response
   // ---------------------------------------------------------------------
   int idle_cycles;

   always @(posedge clock) begin
      alloc_req_type q;
      alloc_rsp_type e;
      bit moved;
      if (!reset) begin
         moved = 1'b0;
         if (req_tvalid && req_tready) begin
            moved = 1'b1;
            q.cmd = req_tuser;
            q.blk = req_tdata[9:0];
            q.ino = req_tdata[19:10];
            q.nbytes = req_tdata[33:20];
            q.fixed = cur_fixed;
            q.fix_status = cur_fix_status;
            q.fix_count = cur_fix_count;
            predict_request(q);
         end
         if (rsp_tvalid && rsp_tready) begin
            moved = 1'b1;
            if (pending_rsps.size() == 0) begin
               $error("unexpected response status=%0d tdata=%h", rsp_tuser, rsp_tdata);
               error_count++;
            end else begin
               e = pending_rsps.pop_front();
               if (rsp_tuser !== e.status) begin
                  $error("status: expected %0d, got %0d", e.status, rsp_tuser);
                  error_count++;
               end
               if (rsp_tdata[9:0] !== e.blk) begin
                  $error("result_block: expected %0d, got %0d", e.blk, rsp_tdata[9:0]);
                  error_count++;
               end
               if (rsp_tdata[19:10] !== e.ino) begin
                  $error("result_inode: expected %0d, got %0d", e.ino, rsp_tdata[19:10]);
                  error_count++;
               end
               if (rsp_tdata[21:20] !== e.kind) begin
                  $error("block_kind: expected %0d, got %0d", e.kind, rsp_tdata[21:20]);
                  error_count++;
               end
               if (rsp_tdata[32:22] !== e.count) begin
                  $error("count: expected %0d, got %0d", e.count, rsp_tdata[32:22]);
                  error_count++;
               end
               if (rsp_tlast !== e.last) begin
                  $error("last: expected %0d, got %0d", e.last, rsp_tlast);
                  error_count++;
               end
            end
         end
         if (moved) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         // covers the clearing pass after reset, a full inode search and
         // the long receiver hold with room to spare
         if (idle_cycles > WATCHDOG_LIMIT) begin
            $display("testbench: errors");
            $finish;
         end
      end
   end

   // mostly back to back, now and then a short pause, rarely a long one
   function automatic int pick_gap();
      int r;
      if (no_idle) return 0;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(15, 60);
   endfunction

   // Receiver: random stalls, plus one long hold-off while requests pile up.
   initial begin
      int gap;
      rsp_tready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            rsp_tready <= 1'b0;
            repeat (400) @(posedge clock);
         end
         gap = pick_gap();
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   end

   // ---------------------------------------------------------------------
   // Sender
   // ---------------------------------------------------------------------
   task automatic send_request(alloc_req_type q);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= q.cmd;
      req_tdata <= {6'd0, q.nbytes, q.ino, q.blk};
      cur_fixed <= q.fixed;
      cur_fix_status <= q.fix_status;
      cur_fix_count <= q.fix_count;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // waits for every response, then lets the block settle before a csr write
   task automatic write_disk_blocks(logic [10:0] value);
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_rsps.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      shadow_blocks_reg = value;
   endtask

   function automatic alloc_req_type make_req(logic [2:0] c, int b, int i, int nb);
      alloc_req_type q;
      q.cmd = c; q.blk = 10'(b); q.ino = 10'(i); q.nbytes = 14'(nb);
      q.fixed = 1'b0; q.fix_status = ST_OK; q.fix_count = '0;
      return q;
   endfunction

   function automatic alloc_req_type make_fixed(logic [2:0] c, int b, int i, int nb,
                                                logic [2:0] st, int cnt);
      alloc_req_type q;
      q = make_req(c, b, i, nb);
      q.fixed = 1'b1; q.fix_status = st; q.fix_count = 11'(cnt);
      return q;
   endfunction

   // random request shaped to the current disk size
   function automatic alloc_req_type random_req();
      int r, b, i, nb;
      logic [2:0] c;
      r = $urandom_range(0, 99);
      if      (r < 3)  c = CMD_FORMAT;
      else if (r < 22) c = CMD_ALLOC;
      else if (r < 48) c = CMD_CREATE;
      else if (r < 57) c = CMD_MARK;
      else if (r < 72) c = CMD_DELETE;
      else if (r < 84) c = CMD_LIST;
      else if (r < 94) c = CMD_STATE;
      else             c = CMD_COUNT;
      if ($urandom_range(0, 9) < 8)
         b = $urandom_range(0, (shadow_disk + 2 > 1023) ? 1023 : shadow_disk + 2);
      else
         b = $urandom_range(0, 1023);
      if ($urandom_range(0, 9) < 8) i = $urandom_range(0, 12);
      else i = $urandom_range(0, 1023);
      r = $urandom_range(0, 9);
      if (r < 1)      nb = 0;
      else if (r < 8) nb = $urandom_range(1, 60);
      else            nb = $urandom_range(0, 16383);
      return make_req(c, b, i, nb);
   endfunction

   alloc_req_type directed_rows [$];
   logic [10:0] phase_sizes [] = '{11'd0, 11'd1, 11'd2047, 11'd7, 11'd40,
                                   11'd1024, 11'd1025, 11'd3};

   initial begin
      error_count = 0;
      idle_cycles = 0;
      no_idle = 1'b0;
      long_hold_req = 1'b0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tuser = CMD_COUNT;
      req_tdata = '0;
      cur_fixed = 1'b0;
      cur_fix_status = ST_OK;
      cur_fix_count = '0;
      csr_valid = 1'b0;
      csr_data = '0;
      shadow_blocks_reg = 11'd1024;
      shadow_disk = 0;
      shadow_fill = 0;
      shadow_clear();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed part: unformatted store first, then a full 1024 block disk.
      directed_rows = '{
         make_fixed(CMD_COUNT, 0, 0, 0, ST_OK, 0),
         make_fixed(CMD_ALLOC, 0, 0, 0, ST_NO_BLOCK, 0),
         make_req(CMD_CREATE, 0, 0, 0),                      // zero-byte create
         make_fixed(CMD_CREATE, 0, 0, 1, ST_TOO_LARGE, 0),
         make_fixed(CMD_MARK, 0, 0, 0, ST_BAD_BLOCK, 0),
         make_fixed(CMD_STATE, 1023, 0, 0, ST_BAD_BLOCK, 0),
         make_fixed(CMD_DELETE, 0, 0, 0, ST_BAD_INODE, 0),
         make_fixed(CMD_LIST, 0, 1023, 0, ST_BAD_INODE, 0),
         make_fixed(CMD_FORMAT, 0, 0, 0, ST_OK, 1024),
         make_req(CMD_ALLOC, 0, 0, 0),
         make_fixed(CMD_CREATE, 0, 0, 16383, ST_TOO_LARGE, 0),
         make_req(CMD_CREATE, 0, 0, 10240),                  // exactly the limit
         make_req(CMD_CREATE, 0, 0, 50),
         make_req(CMD_LIST, 0, 0, 0),
         make_fixed(CMD_MARK, 1023, 0, 0, ST_OK, 0),
         make_req(CMD_STATE, 1023, 0, 0),
         make_req(CMD_STATE, 0, 0, 0),
         make_req(CMD_STATE, 1000, 0, 0),
         make_req(CMD_CREATE, 0, 0, 1),
         make_req(CMD_DELETE, 0, 1, 0),
         make_fixed(CMD_LIST, 0, 1, 0, ST_BAD_INODE, 0),
         make_req(CMD_COUNT, 0, 0, 0),
         make_req(CMD_CREATE, 0, 0, 0),
         make_req(CMD_DELETE, 0, 0, 0)
      };
      foreach (directed_rows[n]) send_request(directed_rows[n]);

      // Random phases, one per disk size; the first one carries the long hold.
      foreach (phase_sizes[p]) begin
         write_disk_blocks(phase_sizes[p]);
         no_idle = (p % 3 == 2);
         send_request(make_req(CMD_FORMAT, 0, 0, 0));
         if (p == 0) long_hold_req = 1'b1;
         repeat (54) send_request(random_req());
         send_request(make_req(CMD_COUNT, 0, 0, 0));
      end
      req_tvalid <= 1'b0;

      @(posedge clock);
      while (pending_rsps.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
      if (error_count == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end

endmodule

FILE: free_block_stack_inode_allocator.f
design/fbsia_pkg.sv
design/fbsia_datapath.sv
design/fbsia_ctrl.sv
design/free_block_stack_inode_allocator.sv
verif/testbench.sv
